### hdl/bmp_pkg.sv
// Shared types and constants of the bitmap header parser and pixel unpacker
package bmp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_SIG    = 2'd1;
  localparam logic [1:0] KIND_DEPTH  = 2'd2;
  localparam logic [1:0] KIND_OFFSET = 2'd3;

  // Header byte positions
  localparam logic [7:0] POS_SIG0   = 8'd0;
  localparam logic [7:0] POS_SIG1   = 8'd1;
  localparam logic [7:0] POS_OFFSET = 8'd10;
  localparam logic [7:0] POS_W_LO   = 8'd18;
  localparam logic [7:0] POS_W_HI   = 8'd19;
  localparam logic [7:0] POS_H_LO   = 8'd22;
  localparam logic [7:0] POS_H_HI   = 8'd23;
  localparam logic [7:0] POS_DEPTH  = 8'd28;
  localparam logic [7:0] POS_SIZE0  = 8'd34;
  localparam logic [7:0] POS_SIZE1  = 8'd35;
  localparam logic [7:0] POS_SIZE2  = 8'd36;
  localparam logic [7:0] POS_SIZE3  = 8'd37;

  // Header values
  localparam logic [7:0] SIG_B      = 8'd66;
  localparam logic [7:0] SIG_M      = 8'd77;
  localparam logic [7:0] MIN_OFFSET = 8'd38;
  localparam logic [7:0] DEPTH24    = 8'd24;
  localparam logic [7:0] DEPTH32    = 8'd32;

  // Datapath operand widths
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 16;

  // Controller to datapath commands
  typedef struct packed {
    logic restart;
    logic hdr_byte;
    logic gap_byte;
    logic pix_byte;
    logic pad_byte;
    logic calc_mul;
    logic calc_sub;
  } bmp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       hdr_err;
    logic [1:0] err_kind;
    logic       hdr_last;
    logic       dim_zero;
    logic       gap_wait;
    logic       pix_done;
    logic       row_end;
    logic       img_end;
    logic       pad_nz;
    logic       pad_last;
    logic       calc_done;
    logic       out_free;
  } bmp_sts_t;

endpackage

### hdl/bmp_if.sv
// Valid/ready channel interfaces for file bytes and results

interface bmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface bmp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       has_alpha;
  logic       last_pixel;

  modport source (output valid, output result_kind, output red, output green, output blue,
                  output alpha, output has_alpha, output last_pixel, input ready);
  modport sink   (input valid, input result_kind, input red, input green, input blue,
                  input alpha, input has_alpha, input last_pixel, output ready);
endinterface

### hdl/bmp_div.sv
// Iterative restoring divider, one quotient bit per cycle
module bmp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [bmp_pkg::DIVIDEND_W-1:0]      dividend,
  input  logic [bmp_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                done,
  output logic [bmp_pkg::DIVIDEND_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(bmp_pkg::DIVIDEND_W);

  logic                             busy_r;
  logic                             done_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [bmp_pkg::DIVIDEND_W-1:0]   quo_r;
  logic [bmp_pkg::DIVISOR_W-1:0]    rem_r;
  logic [bmp_pkg::DIVISOR_W-1:0]    dvs_r;
  logic [bmp_pkg::DIVISOR_W:0]      shifted;
  logic [bmp_pkg::DIVISOR_W:0]      trial;
  logic                             fits;

  // One trial subtraction
  always_comb begin
    shifted = {rem_r, quo_r[bmp_pkg::DIVIDEND_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = shifted >= {1'b0, dvs_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(bmp_pkg::DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[bmp_pkg::DIVIDEND_W-2:0], fits};
      rem_r <= fits ? trial[bmp_pkg::DIVISOR_W-1:0] : shifted[bmp_pkg::DIVISOR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hdl/bmp_dp.sv
// Datapath: header capture, padding calculation, pixel gathering, result register
module bmp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          file_byte,
  input  bmp_pkg::bmp_cmd_t   cmd,
  output bmp_pkg::bmp_sts_t   sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          result_kind,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          alpha,
  output logic                has_alpha,
  output logic                last_pixel
);

  logic [7:0]  pos_r;
  logic [7:0]  offset_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic        alpha_mode_r;
  logic [31:0] size_r;
  logic [31:0] prod_r;
  logic [31:0] row_pad_r;
  logic [23:0] gather_r;
  logic [1:0]  bip_r;
  logic [15:0] col_r;
  logic [15:0] row_r;
  logic [31:0] pad_rem_r;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [7:0]  alpha_r;
  logic        has_alpha_r;
  logic        last_r;

  logic [7:0]  pos_eff;
  logic [33:0] expected;
  logic [31:0] diff;
  logic        div_done;
  logic [31:0] quotient;
  logic        emit_err;
  logic        emit_pix;

  // A start-of-file byte is always byte zero
  assign pos_eff = cmd.restart ? bmp_pkg::POS_SIG0 : pos_r;

  // Status towards the controller
  always_comb begin
    sts          = '0;
    sts.err_kind = bmp_pkg::KIND_PIXEL;
    case (pos_eff)
      bmp_pkg::POS_SIG1: begin
        if (gather_r[7:0] != bmp_pkg::SIG_B || file_byte != bmp_pkg::SIG_M) begin
          sts.hdr_err  = 1'b1;
          sts.err_kind = bmp_pkg::KIND_SIG;
        end
      end
      bmp_pkg::POS_OFFSET: begin
        if (file_byte < bmp_pkg::MIN_OFFSET) begin
          sts.hdr_err  = 1'b1;
          sts.err_kind = bmp_pkg::KIND_OFFSET;
        end
      end
      bmp_pkg::POS_DEPTH: begin
        if (file_byte != bmp_pkg::DEPTH24 && file_byte != bmp_pkg::DEPTH32) begin
          sts.hdr_err  = 1'b1;
          sts.err_kind = bmp_pkg::KIND_DEPTH;
        end
      end
      default: ;
    endcase
    sts.hdr_last  = pos_eff == bmp_pkg::POS_SIZE3;
    sts.dim_zero  = (width_r == 16'd0) || (height_r == 16'd0);
    sts.gap_wait  = pos_r < offset_r;
    sts.pix_done  = bip_r == (alpha_mode_r ? 2'd3 : 2'd2);
    sts.row_end   = ({1'b0, col_r} + 17'd1) >= {1'b0, width_r};
    sts.img_end   = ({1'b0, row_r} + 17'd1) >= {1'b0, height_r};
    sts.pad_nz    = row_pad_r != 32'd0;
    sts.pad_last  = pad_rem_r <= 32'd1;
    sts.calc_done = div_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Surplus bytes over the packed pixel data, clamped at zero
  always_comb begin
    if (alpha_mode_r) begin
      expected = {prod_r, 2'b00};
    end else begin
      expected = {2'b00, prod_r} + {1'b0, prod_r, 1'b0};
    end
    if ({2'b00, size_r} > expected) begin
      diff = size_r - expected[31:0];
    end else begin
      diff = 32'd0;
    end
  end

  bmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.calc_sub),
    .dividend (diff),
    .divisor  (height_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign emit_err = cmd.hdr_byte && sts.hdr_err;
  assign emit_pix = cmd.pix_byte && sts.pix_done;

  // Byte position and pixel counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      bip_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (cmd.hdr_byte || cmd.gap_byte) begin
        pos_r <= pos_eff + 8'd1;
      end
      if (cmd.restart) begin
        bip_r <= '0;
        col_r <= '0;
        row_r <= '0;
      end else if (cmd.pix_byte) begin
        if (sts.pix_done) begin
          bip_r <= '0;
          if (sts.row_end) begin
            col_r <= '0;
            row_r <= row_r + 16'd1;
          end else begin
            col_r <= col_r + 16'd1;
          end
        end else begin
          bip_r <= bip_r + 2'd1;
        end
      end
    end
  end

  // Header fields, gather register, padding
  always_ff @(posedge clk) begin
    if (cmd.hdr_byte) begin
      case (pos_eff)
        bmp_pkg::POS_SIG0:   gather_r <= {16'd0, file_byte};
        bmp_pkg::POS_SIG1:   gather_r <= '0;
        bmp_pkg::POS_OFFSET: offset_r <= file_byte;
        bmp_pkg::POS_W_LO:   width_r[7:0]   <= file_byte;
        bmp_pkg::POS_W_HI:   width_r[15:8]  <= file_byte;
        bmp_pkg::POS_H_LO:   height_r[7:0]  <= file_byte;
        bmp_pkg::POS_H_HI:   height_r[15:8] <= file_byte;
        bmp_pkg::POS_DEPTH:  alpha_mode_r   <= file_byte == bmp_pkg::DEPTH32;
        bmp_pkg::POS_SIZE0:  size_r[7:0]    <= file_byte;
        bmp_pkg::POS_SIZE1:  size_r[15:8]   <= file_byte;
        bmp_pkg::POS_SIZE2:  size_r[23:16]  <= file_byte;
        bmp_pkg::POS_SIZE3:  size_r[31:24]  <= file_byte;
        default: ;
      endcase
    end else if (cmd.pix_byte) begin
      if (sts.pix_done) begin
        gather_r <= '0;
      end else begin
        gather_r[{bip_r, 3'b000} +: 8] <= file_byte;
      end
    end
    if (cmd.calc_mul) begin
      prod_r <= {16'd0, width_r} * {16'd0, height_r};
    end
    if (div_done) begin
      row_pad_r <= quotient;
    end
    if (emit_pix && sts.row_end && !sts.img_end) begin
      pad_rem_r <= row_pad_r;
    end else if (cmd.pad_byte && pad_rem_r != 32'd0) begin
      pad_rem_r <= pad_rem_r - 32'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_err || emit_pix) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_err) begin
      kind_r      <= sts.err_kind;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      alpha_r     <= '0;
      has_alpha_r <= 1'b0;
      last_r      <= 1'b0;
    end else if (emit_pix) begin
      kind_r      <= bmp_pkg::KIND_PIXEL;
      blue_r      <= gather_r[7:0];
      green_r     <= gather_r[15:8];
      red_r       <= alpha_mode_r ? gather_r[23:16] : file_byte;
      alpha_r     <= alpha_mode_r ? file_byte : 8'd0;
      has_alpha_r <= alpha_mode_r;
      last_r      <= sts.row_end && sts.img_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign result_kind = kind_r;
  assign red         = red_r;
  assign green       = green_r;
  assign blue        = blue_r;
  assign alpha       = alpha_r;
  assign has_alpha   = has_alpha_r;
  assign last_pixel  = last_r;

endmodule

### hdl/bmp_ctrl.sv
// Controller: parse phase state machine and padding calculation sequencing
module bmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                start_of_file,
  input  bmp_pkg::bmp_sts_t   sts,
  output logic                in_ready,
  output bmp_pkg::bmp_cmd_t   cmd
);

  localparam logic [2:0] ST_HEADER = 3'd0;
  localparam logic [2:0] ST_GAP    = 3'd1;
  localparam logic [2:0] ST_PIXEL  = 3'd2;
  localparam logic [2:0] ST_PAD    = 3'd3;
  localparam logic [2:0] ST_IDLE   = 3'd4;
  localparam logic [2:0] ST_MUL    = 3'd5;
  localparam logic [2:0] ST_SUB    = 3'd6;
  localparam logic [2:0] ST_DIV    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] phase;
  logic       calc;
  logic       accept;

  // Byte acceptance; stalled while the padding is worked out or while a result waits
  assign calc     = (state_r == ST_MUL) || (state_r == ST_SUB) || (state_r == ST_DIV);
  assign in_ready = !calc && sts.out_free;
  assign accept   = in_valid && in_ready;
  assign phase    = start_of_file ? ST_HEADER : state_r;

  // Commands for the transfer in hand
  always_comb begin
    cmd          = '0;
    cmd.restart  = accept && start_of_file;
    cmd.hdr_byte = accept && (phase == ST_HEADER);
    cmd.gap_byte = accept && (phase == ST_GAP) && sts.gap_wait;
    cmd.pix_byte = accept && ((phase == ST_PIXEL) || ((phase == ST_GAP) && !sts.gap_wait));
    cmd.pad_byte = accept && (phase == ST_PAD);
    cmd.calc_mul = state_r == ST_MUL;
    cmd.calc_sub = state_r == ST_SUB;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_MUL: state_nxt = ST_SUB;
      ST_SUB: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.calc_done) begin
          state_nxt = ST_GAP;
        end
      end
      default: begin
        if (accept) begin
          case (phase)
            ST_HEADER: begin
              if (sts.hdr_err) begin
                state_nxt = ST_IDLE;
              end else if (sts.hdr_last) begin
                state_nxt = sts.dim_zero ? ST_IDLE : ST_MUL;
              end else begin
                state_nxt = ST_HEADER;
              end
            end
            ST_GAP, ST_PIXEL: begin
              if (phase == ST_GAP && sts.gap_wait) begin
                state_nxt = ST_GAP;
              end else if (sts.pix_done && sts.row_end) begin
                if (sts.img_end) begin
                  state_nxt = ST_IDLE;
                end else begin
                  state_nxt = sts.pad_nz ? ST_PAD : ST_PIXEL;
                end
              end else begin
                state_nxt = ST_PIXEL;
              end
            end
            ST_PAD: state_nxt = sts.pad_last ? ST_PIXEL : ST_PAD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // Multiply step is always followed by the subtract step
  a_mul_then_sub: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |=> state_r == ST_SUB)
    else $error("padding calculation skipped the subtract step");

  // Divider finishes only while the controller waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.calc_done |-> state_r == ST_DIV)
    else $error("divider finished outside the wait state");

  // A header error stops the parser
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hdr_byte && sts.hdr_err) |=> state_r == ST_IDLE)
    else $error("parser kept running after a header error");

  // The final pixel stops the parser
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pix_byte && sts.pix_done && sts.row_end && sts.img_end) |=> state_r == ST_IDLE)
    else $error("parser kept running after the final pixel");
`endif

endmodule

### hdl/bmp_header_and_pixel_unpacker.sv
// Top level: bitmap header parser and pixel unpacker
//
//  Channel  Direction  Handshake    Payload
//  in_ch    sink       valid/ready  file_byte[7:0], start_of_file
//  out_ch   source     valid/ready  result_kind[1:0], red, green, blue, alpha, has_alpha,
//                                   last_pixel
//
// One file byte is taken per cycle unless the input stalls; a byte gives at most
// one result, held in an output register, so a byte is taken in the cycle its
// predecessor's result leaves. After header byte 37 of an image with nonzero width
// and height, the input stalls while the row padding is derived: a multiply step, a
// subtract step and the serial divider (32 quotient steps, then its done flag).
// Reset is synchronous and active low; the first byte after reset counts as byte zero.
// The input also stalls while a result waits and out_ch.ready is low.
module bmp_header_and_pixel_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  bmp_in_if.sink      in_ch,
  bmp_out_if.source   out_ch
);

  bmp_pkg::bmp_cmd_t cmd;
  bmp_pkg::bmp_sts_t sts;

  bmp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .start_of_file (in_ch.start_of_file),
    .sts           (sts),
    .in_ready      (in_ch.ready),
    .cmd           (cmd)
  );

  bmp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .file_byte     (in_ch.file_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .result_kind   (out_ch.result_kind),
    .red           (out_ch.red),
    .green         (out_ch.green),
    .blue          (out_ch.blue),
    .alpha         (out_ch.alpha),
    .has_alpha     (out_ch.has_alpha),
    .last_pixel    (out_ch.last_pixel)
  );

endmodule

### dv/bmp_unpack_checker.sv
// Checker for the bitmap unpacker: watches both channels, predicts results and compares them
`timescale 1ns / 1ps

module bmp_unpack_checker (
  input  logic        clk,
  input  logic        rst_n,
  bmp_in_if           in_ch,
  bmp_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  import bmp_pkg::*;

  typedef enum logic [2:0] {ST_HEADER, ST_GAP, ST_PIXEL, ST_PAD, ST_IDLE} parse_st_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic       last_pixel;
  } bmp_res_t;

  // Results still to come out of the block, oldest first
  bmp_res_t unpacked_q[$];

  // Parser state of the prediction
  logic [39:0] file_pos;
  parse_st_t   phase;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [7:0]  offset_r;
  logic [7:0]  depth_r;
  logic [31:0] size_r;
  logic [31:0] pad_r;
  logic [23:0] gather;
  logic [1:0]  gather_idx;
  logic [15:0] col;
  logic [15:0] row;
  logic [31:0] pad_left;

  function automatic void clear_parser();
    file_pos   = '0;
    phase      = ST_HEADER;
    width_r    = '0;
    height_r   = '0;
    offset_r   = '0;
    depth_r    = '0;
    size_r     = '0;
    pad_r      = '0;
    gather     = '0;
    gather_idx = '0;
    col        = '0;
    row        = '0;
    pad_left   = '0;
  endfunction

  function automatic bit raise_error(input logic [1:0] kind, output bmp_res_t res);
    res      = '0;
    res.kind = kind;
    phase    = ST_IDLE;
    return 1'b1;
  endfunction

  // Advance the parser by one file byte; returns 1 when the byte yields a result
  function automatic bit unpack_byte(input logic [7:0] b, input logic sof, output bmp_res_t res);
    logic [39:0] pos;
    logic [63:0] bpb;
    logic [63:0] need;
    bit          with_alpha;
    logic [2:0]  need_bytes;

    res = '0;
    if (sof) clear_parser();
    pos = file_pos;

    if (phase == ST_HEADER) begin
      file_pos = file_pos + 40'd1;
      case (pos)
        POS_SIG0: gather = {16'd0, b};
        POS_SIG1: begin
          if (gather != {16'd0, SIG_B} || b != SIG_M) return raise_error(KIND_SIG, res);
          gather = '0;
        end
        POS_OFFSET: begin
          offset_r = b;
          if (b < MIN_OFFSET) return raise_error(KIND_OFFSET, res);
        end
        POS_W_LO: width_r[7:0]   = b;
        POS_W_HI: width_r[15:8]  = b;
        POS_H_LO: height_r[7:0]  = b;
        POS_H_HI: height_r[15:8] = b;
        POS_DEPTH: begin
          depth_r = b;
          if (b != DEPTH24 && b != DEPTH32) return raise_error(KIND_DEPTH, res);
        end
        POS_SIZE0: size_r = {24'd0, b};
        POS_SIZE1: size_r[15:8] = b;
        POS_SIZE2: size_r[23:16] = b;
        POS_SIZE3: begin
          size_r[31:24] = b;
          // padding per row, clamped at zero
          bpb  = (depth_r == DEPTH32) ? 64'd4 : 64'd3;
          need = 64'(width_r) * 64'(height_r) * bpb;
          if (height_r == 16'd0 || 64'(size_r) <= need) pad_r = '0;
          else pad_r = 32'((64'(size_r) - need) / 64'(height_r));
          phase = (width_r == 16'd0 || height_r == 16'd0) ? ST_IDLE : ST_GAP;
        end
        default: ;
      endcase
      return 1'b0;
    end

    // bytes between the header and the pixel data
    if (phase == ST_GAP) begin
      if (pos < 40'(offset_r)) begin
        file_pos = file_pos + 40'd1;
        return 1'b0;
      end
      phase = ST_PIXEL;
    end

    if (phase == ST_PAD) begin
      if (pad_left > 32'd0) pad_left = pad_left - 32'd1;
      if (pad_left == 32'd0) phase = ST_PIXEL;
      return 1'b0;
    end

    if (phase != ST_PIXEL) return 1'b0;

    with_alpha = (depth_r == DEPTH32);
    need_bytes = with_alpha ? 3'd4 : 3'd3;

    if (3'(gather_idx) + 3'd1 < need_bytes) begin
      gather     = gather | ({16'd0, b} << (8 * gather_idx));
      gather_idx = gather_idx + 2'd1;
      return 1'b0;
    end
    if (!with_alpha) gather[23:16] = gather[23:16] | b;

    res.kind      = KIND_PIXEL;
    res.blue      = gather[7:0];
    res.green     = gather[15:8];
    res.red       = gather[23:16];
    res.alpha     = with_alpha ? b : 8'd0;
    res.has_alpha = with_alpha;

    gather     = '0;
    gather_idx = '0;
    col        = col + 16'd1;
    if (col >= width_r) begin
      col = '0;
      row = row + 16'd1;
      if (row >= height_r) begin
        res.last_pixel = 1'b1;
        phase          = ST_IDLE;
      end else if (pad_r > 32'd0) begin
        pad_left = pad_r;
        phase    = ST_PAD;
      end
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Sample both channels at the rising edge; outputs are compared before new bytes are predicted
  always @(posedge clk) begin
    bmp_res_t want;
    bmp_res_t got;
    bmp_res_t fresh;
    if (!rst_n) begin
      clear_parser();
      unpacked_q.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.result_kind, out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                out_ch.has_alpha, out_ch.last_pixel};
        if (unpacked_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer, expected none actual kind %0d",
                   $time, got.kind);
        end else begin
          want = unpacked_q.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
          check_field("has_alpha", want.has_alpha, got.has_alpha);
          check_field("last_pixel", want.last_pixel, got.last_pixel);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (unpack_byte(in_ch.file_byte, in_ch.start_of_file, fresh))
          unpacked_q = {unpacked_q, fresh};
      end
    end
    pending_count <= unpacked_q.size();
  end

endmodule

### dv/bmp_header_and_pixel_unpacker_tb.sv
// Testbench top for the bitmap unpacker: clock, reset, byte stream, result sink and verdict
`timescale 1ns / 1ps

module bmp_header_and_pixel_unpacker_tb;
  import bmp_pkg::*;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending_count;

  // Stimulus controls; idle_on and hold_req are shared with the result sink
  bit          idle_on;
  bit          hold_req;
  longint      sent_bytes;

  bmp_in_if  in_ch ();
  bmp_out_if out_ch ();

  bmp_header_and_pixel_unpacker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bmp_unpack_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result sink: random stall bursts, plus one long hold-off to back the block up
  initial begin
    int stall;
    bit held;
    stall         = 0;
    held          = 1'b0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (250) @(negedge clk);
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 16) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One byte transfer, entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic sof);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid     <= 1'b0;
      in_ch.file_byte <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.file_byte     <= b;
    in_ch.start_of_file <= sof;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pixel_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // A whole file: header, gap, pixel rows with padding; cut >= 0 truncates it
  task automatic send_file(input logic sof0, input logic [7:0] sig0, input logic [7:0] sig1,
                           input logic [7:0] offset, input logic [7:0] depth,
                           input logic [15:0] w, input logic [15:0] h,
                           input logic [31:0] size, input longint cut, input int tail,
                           input bit hold);
    logic [7:0]      hdr [38];
    longint unsigned bpb;
    longint unsigned pad;
    longint unsigned full;
    longint          total;
    logic [7:0]      b;

    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[POS_SIG0]   = sig0;
    hdr[POS_SIG1]   = sig1;
    hdr[POS_OFFSET] = offset;
    hdr[POS_W_LO]   = w[7:0];
    hdr[POS_W_HI]   = w[15:8];
    hdr[POS_H_LO]   = h[7:0];
    hdr[POS_H_HI]   = h[15:8];
    hdr[POS_DEPTH]  = depth;
    hdr[POS_SIZE0]  = size[7:0];
    hdr[POS_SIZE1]  = size[15:8];
    hdr[POS_SIZE2]  = size[23:16];
    hdr[POS_SIZE3]  = size[31:24];

    // whole file length; pixel data and padding count only for a header the block accepts
    bpb  = (depth == DEPTH32) ? 4 : 3;
    full = 38;
    if (sig0 == SIG_B && sig1 == SIG_M && offset >= MIN_OFFSET &&
        (depth == DEPTH24 || depth == DEPTH32) && w != 0 && h != 0) begin
      if (size <= w * h * bpb) pad = 0;
      else pad = (size - w * h * bpb) / h;
      full = offset + w * h * bpb + pad * (h - 1);
    end
    total = (cut >= 0 && cut < full) ? cut : full;

    for (longint i = 0; i < total; i++) begin
      b = (i < 38) ? hdr[i] : pixel_byte();
      if (hold && i == offset) hold_req = 1'b1;
      push_byte(b, (i == 0) ? sof0 : 1'b0);
    end
    repeat (tail) push_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    longint      target;
    int          sel;
    int          n;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [7:0]  off;
    logic [7:0]  dep;
    logic [31:0] size;
    int unsigned bpb;
    int unsigned pad;
    longint      cut;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.file_byte     = 8'd0;
    in_ch.start_of_file = 1'b0;
    idle_on             = 1'b1;
    hold_req            = 1'b0;
    sent_bytes          = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed files; the first one comes without a start marker and backs the block up
    send_file(1'b0, SIG_B, SIG_M, 8'd38, DEPTH24, 16'd2, 16'd2, 32'd14, -1, 0, 1'b1);
    send_file(1'b1, SIG_B, SIG_M, 8'd41, DEPTH32, 16'd3, 16'd1, 32'd0, -1, 3, 1'b0);
    send_file(1'b1, 8'h41, SIG_M, 8'd38, DEPTH24, 16'd1, 16'd1, 32'd3, -1, 4, 1'b0);
    send_file(1'b1, SIG_B, 8'h4E, 8'd20, 8'd8, 16'd1, 16'd1, 32'd3, -1, 2, 1'b0);
    send_file(1'b1, SIG_B, SIG_M, 8'd37, DEPTH24, 16'd1, 16'd1, 32'd3, -1, 2, 1'b0);
    send_file(1'b1, SIG_B, SIG_M, 8'd0, 8'd16, 16'd1, 16'd1, 32'd3, -1, 0, 1'b0);
    send_file(1'b1, SIG_B, SIG_M, 8'd38, 8'd16, 16'd1, 16'd1, 32'd3, -1, 2, 1'b0);
    send_file(1'b1, SIG_B, SIG_M, 8'd255, 8'd255, 16'd1, 16'd1, 32'd3, -1, 0, 1'b0);
    // zero width, then zero height with a huge image size
    send_file(1'b1, SIG_B, SIG_M, 8'd38, DEPTH24, 16'd0, 16'd3, 32'd100, -1, 3, 1'b0);
    send_file(1'b1, SIG_B, SIG_M, 8'd38, DEPTH32, 16'd2, 16'd0, 32'hFFFF_FFFF, -1, 3, 1'b0);
    // largest sizes, cut short by the next file
    send_file(1'b1, SIG_B, SIG_M, 8'd38, DEPTH24, 16'hFFFF, 16'd1, 32'hFFFF_FFFF, 70, 0, 1'b0);
    send_file(1'b1, SIG_B, SIG_M, 8'd255, DEPTH32, 16'd1, 16'hFFFF, 32'd0, 300, 0, 1'b0);
    // padding with a remainder in the division
    send_file(1'b1, SIG_B, SIG_M, 8'd38, DEPTH24, 16'd1, 16'd3, 32'd16, -1, 1, 1'b0);
    // restart in the middle of pixel data
    send_file(1'b1, SIG_B, SIG_M, 8'd39, DEPTH32, 16'd4, 16'd2, 32'd40, 50, 0, 1'b0);

    // Random files, mostly well formed, up to the total byte budget
    target = 950;
    while (sent_bytes < target) begin
      if (sent_bytes + 150 >= target) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);

      sel  = $urandom_range(0, 99);
      w    = 16'($urandom_range(1, 5));
      h    = 16'($urandom_range(1, 4));
      dep  = $urandom_range(0, 1) ? DEPTH32 : DEPTH24;
      off  = 8'($urandom_range(38, 46));
      bpb  = (dep == DEPTH32) ? 4 : 3;
      pad  = $urandom_range(0, 3);
      size = w * h * bpb + pad * h + $urandom_range(0, h - 1);
      if ($urandom_range(0, 7) == 0) size = $urandom_range(0, w * h * bpb);
      cut  = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(1, 60)) : -1;
      s0   = SIG_B;
      s1   = SIG_M;

      if (sel < 70) begin
        send_file(1'b1, s0, s1, off, dep, w, h, size, cut, $urandom_range(0, 1) * 3,
                  !hold_req && sent_bytes > target - 700);
      end else if (sel < 80) begin
        case ($urandom_range(0, 3))
          0: begin
            s0 = 8'($urandom);
            if (s0 == SIG_B) s0 = ~s0;
          end
          1: begin
            s1 = 8'($urandom);
            if (s1 == SIG_M) s1 = ~s1;
          end
          2: off = 8'($urandom_range(0, 37));
          default: begin
            dep = 8'($urandom);
            if (dep == DEPTH24 || dep == DEPTH32) dep = dep ^ 8'd1;
          end
        endcase
        send_file(1'b1, s0, s1, off, dep, w, h, size, -1, $urandom_range(0, 4), 1'b0);
      end else if (sel < 88) begin
        if ($urandom_range(0, 1)) w = '0;
        else h = '0;
        if ($urandom_range(0, 1)) begin
          if (w != 0) w = 16'($urandom);
          if (h != 0) h = 16'($urandom);
        end
        send_file(1'b1, s0, s1, off, dep, w, h, $urandom, -1, $urandom_range(0, 4), 1'b0);
      end else begin
        // loose bytes, now and then with a start marker
        n = $urandom_range(5, 30);
        repeat (n) push_byte(8'($urandom), ($urandom_range(0, 15) == 0));
      end
    end

    in_ch.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
